// ----- rtl/ps2_mouse_cursor_tracker_assert.svh -----
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker_assert.svh
// Assertion macros used by the cursor tracker top level.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_CURSOR_TRACKER_ASSERT_SVH
`define PS2_MOUSE_CURSOR_TRACKER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PS2MCT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PS2MCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ps2mct_pkg.sv -----
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Types and constants of the PS/2 mouse cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned LIMIT_W  = 12;
  localparam int unsigned BTN_W    = 3;
  localparam int unsigned HDR_W    = 6;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;

  // Default coordinate width of the cursor
  localparam int unsigned COORD_BITS_DEF = 12;

  // Header bits
  localparam int unsigned SYNC_BIT_IDX  = 3;
  localparam int unsigned XSIGN_BIT_IDX = 4;
  localparam int unsigned YSIGN_BIT_IDX = 5;

  // A negative delta is the data byte minus this span
  localparam int unsigned DELTA_SPAN = 256;

  // Reset values of the clamp bounds
  localparam logic [LIMIT_W-1:0] LIMIT_X_RST = LIMIT_W'(1920);
  localparam logic [LIMIT_W-1:0] LIMIT_Y_RST = LIMIT_W'(1080);

  // Register map index (byte address 4*index)
  typedef enum logic [0:0] {
    REG_LIMIT_X = 1'b0,
    REG_LIMIT_Y = 1'b1
  } reg_idx_e;

  // Clamp bounds handed to the datapath
  typedef struct packed {
    logic [LIMIT_W-1:0] limit_x;
    logic [LIMIT_W-1:0] limit_y;
  } limits_t;

  // One result beat
  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [BTN_W-1:0] buttons;
  } result_t;

endpackage

// ----- rtl/ps2mct_if.sv -----
// ----------------------------------------------------------------------------
// ps2mct_if
// Valid/ready channels of the cursor tracker: raw bytes in, results out.
// ----------------------------------------------------------------------------
interface ps2mct_byte_if;
  logic                           valid;
  logic                           ready;
  logic [ps2mct_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ps2mct_pos_if;
  logic                          valid;
  logic                          ready;
  logic [ps2mct_pkg::POS_W-1:0] pos_x;
  logic [ps2mct_pkg::POS_W-1:0] pos_y;
  logic [ps2mct_pkg::BTN_W-1:0] buttons;

  modport source (output valid, output pos_x, output pos_y, output buttons, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input buttons, output ready);
endinterface

// ----- rtl/ps2mct_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ps2mct_cfg_regs
// APB register file holding the x and y clamp bounds.
// ----------------------------------------------------------------------------
module ps2mct_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ps2mct_pkg::APB_AW-1:0] paddr,
  input  logic [ps2mct_pkg::APB_DW-1:0] pwdata,
  output logic [ps2mct_pkg::APB_DW-1:0] prdata,
  output logic                           pready,
  output ps2mct_pkg::limits_t            limits_o
);

  logic [ps2mct_pkg::LIMIT_W-1:0] limit_x_q;
  logic [ps2mct_pkg::LIMIT_W-1:0] limit_y_q;
  ps2mct_pkg::reg_idx_e           reg_idx;
  logic                           wr_en;

  // Decode register index from the word address
  assign reg_idx = ps2mct_pkg::reg_idx_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Write the addressed bound
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_x_q <= ps2mct_pkg::LIMIT_X_RST;
      limit_y_q <= ps2mct_pkg::LIMIT_Y_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        ps2mct_pkg::REG_LIMIT_X: limit_x_q <= pwdata[ps2mct_pkg::LIMIT_W-1:0];
        ps2mct_pkg::REG_LIMIT_Y: limit_y_q <= pwdata[ps2mct_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed bound
  always_comb begin
    unique case (reg_idx)
      ps2mct_pkg::REG_LIMIT_X: prdata = ps2mct_pkg::APB_DW'(limit_x_q);
      ps2mct_pkg::REG_LIMIT_Y: prdata = ps2mct_pkg::APB_DW'(limit_y_q);
      default:                 prdata = '0;
    endcase
  end

  assign limits_o.limit_x = limit_x_q;
  assign limits_o.limit_y = limit_y_q;

endmodule

// ----- rtl/ps2mct_axis_move.sv -----
// ----------------------------------------------------------------------------
// ps2mct_axis_move
// Adds a 9-bit signed delta to one cursor axis and clamps it to 0..bound.
// ----------------------------------------------------------------------------
module ps2mct_axis_move #(
  parameter int unsigned COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0]              pos_i,
  input  logic [ps2mct_pkg::BYTE_W-1:0]      delta_i,
  input  logic                               neg_i,
  input  logic [ps2mct_pkg::LIMIT_W-1:0]     limit_i,
  output logic [COORD_BITS-1:0]              pos_o
);

  // Wide enough for the bound and the coordinate, plus carry and sign
  localparam int unsigned LW = (COORD_BITS > ps2mct_pkg::LIMIT_W) ?
                               COORD_BITS : ps2mct_pkg::LIMIT_W;
  localparam int unsigned SW = LW + 2;
  localparam logic [LW-1:0] CeilMax = LW'((64'd1 << COORD_BITS) - 64'd1);

  logic [LW-1:0] lim_ext;
  logic [LW-1:0] top;
  logic [SW-1:0] sum;

  // Saturate the bound at the coordinate range
  assign lim_ext = LW'(limit_i);
  assign top     = (lim_ext > CeilMax) ? CeilMax : lim_ext;

  // Sign-extend the delta by subtracting the span when negative
  assign sum = SW'(pos_i) + SW'(delta_i)
             - (neg_i ? SW'(ps2mct_pkg::DELTA_SPAN) : SW'(0));

  // Clamp below at zero and above at the bound
  always_comb begin
    if (sum[SW-1]) begin
      pos_o = '0;
    end else if (sum > SW'(top)) begin
      pos_o = COORD_BITS'(top);
    end else begin
      pos_o = COORD_BITS'(sum);
    end
  end

endmodule

// ----- rtl/ps2mct_pkt_decode.sv -----
// ----------------------------------------------------------------------------
// ps2mct_pkt_decode
// Packet framing, byte holds and cursor state; forms one result per packet.
// ----------------------------------------------------------------------------
module ps2mct_pkt_decode #(
  parameter int unsigned COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic [ps2mct_pkg::BYTE_W-1:0] byte_i,
  input  ps2mct_pkg::limits_t            limits_i,
  output logic                           emit_o,
  output ps2mct_pkg::result_t            res_o
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DX     = 2'd1,
    PH_DY     = 2'd2
  } phase_e;

  phase_e                           phase_q, phase_d;
  logic [ps2mct_pkg::HDR_W-1:0]    hdr_q, hdr_d;
  logic [ps2mct_pkg::BYTE_W-1:0]   dx_q, dx_d;
  logic [COORD_BITS-1:0]           cur_x_q, cur_x_d;
  logic [COORD_BITS-1:0]           cur_y_q, cur_y_d;
  logic [COORD_BITS-1:0]           mov_x, mov_y;
  logic [ps2mct_pkg::BTN_W-1:0]    btn;

  assign btn = hdr_q[ps2mct_pkg::BTN_W-1:0];

  // Candidate positions for a motion packet
  ps2mct_axis_move #(.COORD_BITS(COORD_BITS)) u_move_x (
    .pos_i   (cur_x_q),
    .delta_i (dx_q),
    .neg_i   (hdr_q[ps2mct_pkg::XSIGN_BIT_IDX]),
    .limit_i (limits_i.limit_x),
    .pos_o   (mov_x)
  );

  ps2mct_axis_move #(.COORD_BITS(COORD_BITS)) u_move_y (
    .pos_i   (cur_y_q),
    .delta_i (byte_i),
    .neg_i   (hdr_q[ps2mct_pkg::YSIGN_BIT_IDX]),
    .limit_i (limits_i.limit_y),
    .pos_o   (mov_y)
  );

  // The dy byte completes a packet
  assign emit_o = (phase_q == PH_DY);

  // Advance framing and cursor
  always_comb begin
    phase_d = phase_q;
    hdr_d   = hdr_q;
    dx_d    = dx_q;
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    unique case (phase_q)
      PH_DX: begin
        dx_d    = byte_i;
        phase_d = PH_DY;
      end
      PH_DY: begin
        phase_d = PH_HEADER;
        if (btn == '0) begin
          cur_x_d = mov_x;
          cur_y_d = mov_y;
        end
      end
      default: begin
        // Drop bytes without the sync bit to regain framing
        phase_d = PH_HEADER;
        if (byte_i[ps2mct_pkg::SYNC_BIT_IDX]) begin
          hdr_d   = byte_i[ps2mct_pkg::HDR_W-1:0];
          phase_d = PH_DX;
        end
      end
    endcase
  end

  assign res_o.pos_x   = ps2mct_pkg::POS_W'(cur_x_d);
  assign res_o.pos_y   = ps2mct_pkg::POS_W'(cur_y_d);
  assign res_o.buttons = btn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hdr_q   <= '0;
      dx_q    <= '0;
      cur_x_q <= '0;
      cur_y_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      dx_q    <= dx_d;
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
    end
  end

endmodule

// ----- rtl/ps2_mouse_cursor_tracker.sv -----
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker
// Decodes PS/2 mouse packets and tracks a clamped cursor position.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries raw mouse bytes (rx_byte), one per beat.
//   out_ch carries one beat per complete three-byte packet: pos_x, pos_y and
//          buttons. A packet with a button held reports the buttons and the
//          unchanged cursor; a motion packet reports buttons of zero.
//   The APB port holds limit_x at 0x0 and limit_y at 0x4; write them only
//   while the block is idle.
// Timing:
//   One byte is taken every cycle unless a result stall holds the flow. Each
//   byte is held in the input register; the result of a dy byte moves from it
//   into the result register. The add and clamp of both axes are combinational
//   between the input register and the result register.
// Reset:
//   Framing returns to awaiting header, the cursor goes to 0,0, the bounds
//   to 1920 and 1080; no result beat is pending.
// Stall:
//   While out_ch is stalled, one more result waits in the input register;
//   bytes that complete no packet keep flowing through.
// ----------------------------------------------------------------------------
`include "ps2_mouse_cursor_tracker_assert.svh"

module ps2_mouse_cursor_tracker #(
  parameter int unsigned COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ps2mct_byte_if.sink                    in_ch,
  ps2mct_pos_if.source                   out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ps2mct_pkg::APB_AW-1:0] paddr,
  input  logic [ps2mct_pkg::APB_DW-1:0] pwdata,
  output logic [ps2mct_pkg::APB_DW-1:0] prdata,
  output logic                           pready
);

  ps2mct_pkg::limits_t            limits;
  ps2mct_pkg::result_t            res;
  ps2mct_pkg::result_t            out_res_q;
  logic                           out_valid_q;
  logic                           in_valid_q;
  logic [ps2mct_pkg::BYTE_W-1:0] in_byte_q;
  logic                           emit;
  logic                           out_free;
  logic                           step;

  ps2mct_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .limits_o (limits)
  );

  ps2mct_pkt_decode #(.COORD_BITS(COORD_BITS)) u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .limits_i (limits),
    .emit_o   (emit),
    .res_o    (res)
  );

  // Advance a held byte unless its result has nowhere to go
  assign out_free    = !out_valid_q || out_ch.ready;
  assign step        = in_valid_q && (!emit || out_free);
  assign in_ch.ready = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_q <= in_ch.rx_byte;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_res_q <= res;
    end
  end

  assign out_ch.valid   = out_valid_q;
  assign out_ch.pos_x   = out_res_q.pos_x;
  assign out_ch.pos_y   = out_res_q.pos_y;
  assign out_ch.buttons = out_res_q.buttons;

  // Hold a completing byte while the result register is blocked
  `PS2MCT_ASSERT_NEXT(a_hold_blocked, clk_i, rst_ni, in_valid_q && emit && !out_free, in_valid_q && $stable(in_byte_q), "completing byte lost while result register blocked")
  // Every completed packet lands in the result register
  `PS2MCT_ASSERT_NEXT(a_emit_loads, clk_i, rst_ni, step && emit, out_valid_q, "completed packet not loaded into result register")
  // An accepted byte is held in the input register
  `PS2MCT_ASSERT_NEXT(a_accept_held, clk_i, rst_ni, in_ch.valid && in_ch.ready, in_valid_q, "accepted byte not captured")
  // Never overwrite a result that is still waiting
  `PS2MCT_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, out_valid_q && !out_ch.ready, !(step && emit), "pending result overwritten")

endmodule
